@@ hdl/tty_ld_pkg.sv @@
// Package for the tty line discipline: register indexes, flag bits, types.
// No dependencies.
`timescale 1ns / 1ps
package tty_ld_pkg;
  localparam int BufDepth = 64;
  localparam int SlotW = $clog2(BufDepth);
  localparam int IdxW = SlotW + 1;
  localparam int RingSpan = 2 * BufDepth;
  localparam int CfgW = 32;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegIflag = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLflag = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOflag = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSig = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEdit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLend = 3'd5;

  localparam logic [1:0] OpRecv = 2'd0;
  localparam logic [1:0] OpRead = 2'd1;
  localparam logic [1:0] OpXmit = 2'd2;
  localparam logic [1:0] OpSpare = 2'd3;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindEmit = 2'd1;
  localparam logic [1:0] KindRub = 2'd2;
  localparam logic [1:0] KindRead = 2'd3;

  localparam logic [7:0] ChNl = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChCaret = 8'h5e;
  localparam logic [7:0] ChAt = 8'h40;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel = 8'h7f;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [1:0] out_count;
    logic [1:0] signal_raised;
    logic       reader_wake;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_eol;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StRecv, StStore, StRubRd, StRubWait, StRubChk, StRead, StReadWait, StEmit
  } state_e;

  function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] i);
    return (i == IdxW'(RingSpan - 1)) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [IdxW-1:0] retreat(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(RingSpan - 1) : i - 1'b1;
  endfunction
  function automatic logic [SlotW-1:0] slot(input logic [IdxW-1:0] i);
    return (i >= IdxW'(BufDepth)) ? SlotW'(i - IdxW'(BufDepth)) : i[SlotW-1:0];
  endfunction
  function automatic logic match(input logic [7:0] c, input logic [7:0] v);
    return (v != 8'd0) && (c == v);
  endfunction
endpackage

@@ hdl/tty_ld_if.sv @@
// Valid/ready channel interface carrying one payload.
// Depends on nothing but the payload type given as a parameter.
`timescale 1ns / 1ps
interface tty_ld_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hdl/tty_ld_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tty_ld_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/tty_canonical_line_discipline.sv @@
// Top level of the tty canonical line discipline.
// Depends on tty_ld_pkg, tty_ld_if and tty_ld_ram.
//
// Usage: in_ch carries {operation, byte_in}; out_ch carries one or more result
// items per input, the final one flagged by last. Configuration is written
// through cfg_we_i / cfg_idx_i / cfg_data_i while no item is in flight.
// A new input is taken only after the last result of the previous one has
// been transferred out; one item is worked on at a time.
// A transmit or spare operation goes from idle straight to the emit state; a
// receive passes the receive state when dropped or consumed by a signal or
// literal next, and the store state as well when stored; a read passes the
// read and read-wait states, waiting on the registered line store read.
// Erase, kill and word erase walk the line back one byte at a time (read of
// the store, compare, rub out). In kill and word erase each rub out is held
// one step so that the final one can carry last.
// Each emitted item sits in the output register until taken; a stalled
// receiver holds the engine in its emit state or in the rub-out walk.
// Reset: indices, column and literal flag clear, registers take their
// documented defaults. The line store is not cleared; unwritten entries are
// never read.
`timescale 1ns / 1ps
module tty_canonical_line_discipline (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tty_ld_if.sink                              in_ch,
  tty_ld_if.source                            out_ch,
  input  logic                                cfg_we_i,
  input  logic [tty_ld_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tty_ld_pkg::CfgW-1:0]         cfg_data_i
);
  localparam int IdxW = tty_ld_pkg::IdxW;
  localparam int SlotW = tty_ld_pkg::SlotW;

  localparam logic [1:0] ModeErase = 2'd0;
  localparam logic [1:0] ModeKill = 2'd1;
  localparam logic [1:0] ModeWordSp = 2'd2;
  localparam logic [1:0] ModeWordCh = 2'd3;

  logic [2:0]  iflag_q;
  logic [7:0]  lflag_q;
  logic [1:0]  oflag_q;
  logic [23:0] sig_q;
  logic [31:0] edit_q;
  logic [15:0] lend_q;

  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d, le_q, le_d;
  logic            lit_q, lit_d;
  logic [15:0]     col_q, col_d;

  tty_ld_pkg::state_e state_q, state_d;
  logic [7:0] c_q, c_d;
  logic [1:0] op_q, op_d;
  logic [1:0] mode_q, mode_d;
  logic [1:0] sigc_q, sigc_d;
  logic       wake_q, wake_d;
  logic       eolf_q, eolf_d;
  logic       hold_q, hold_d;      // a rub out waits to learn whether it is the last
  logic [1:0] hcnt_q, hcnt_d;

  tty_ld_pkg::out_item_t ob_q, ob_d;
  logic ov_q, ov_d;

  logic             ram_we;
  logic [SlotW-1:0] ram_wa, ram_ra;
  logic [7:0]       ram_rd;

  tty_ld_ram #(.Width(8), .Depth(tty_ld_pkg::BufDepth)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(c_q),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  wire canon = lflag_q[1];
  wire echo_on = lflag_q[2];
  wire echoe = lflag_q[3];
  wire echoctl = lflag_q[4];
  wire ext = lflag_q[6];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iflag_q <= 3'd2;
      lflag_q <= 8'd95;
      oflag_q <= 2'd3;
      sig_q   <= 24'h1A1C03;
      edit_q  <= 32'h1617157F;
      lend_q  <= 16'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tty_ld_pkg::RegIflag: iflag_q <= cfg_data_i[2:0];
        tty_ld_pkg::RegLflag: lflag_q <= cfg_data_i[7:0];
        tty_ld_pkg::RegOflag: oflag_q <= cfg_data_i[1:0];
        tty_ld_pkg::RegSig:   sig_q   <= cfg_data_i[23:0];
        tty_ld_pkg::RegEdit:  edit_q  <= cfg_data_i;
        tty_ld_pkg::RegLend:  lend_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tty_ld_pkg::StIdle;
      wr_q <= '0; rd_q <= '0; le_q <= '0;
      lit_q <= 1'b0; col_q <= '0; ov_q <= 1'b0;
      sigc_q <= '0; wake_q <= 1'b0; hold_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q <= wr_d; rd_q <= rd_d;
      // leaving canonical mode pins the line end to the write index
      if (cfg_we_i && cfg_idx_i == tty_ld_pkg::RegLflag && canon && !cfg_data_i[1])
        le_q <= wr_q;
      else
        le_q <= le_d;
      lit_q <= lit_d; col_q <= col_d; ov_q <= ov_d;
      sigc_q <= sigc_d; wake_q <= wake_d; hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; op_q <= op_d; mode_q <= mode_d; eolf_q <= eolf_d; ob_q <= ob_d;
    hcnt_q <= hcnt_d;
  end

  // Output processing of c: fills ob and moves the column.
  function automatic void put_out(input logic [7:0] c, input logic [1:0] of,
                                  inout logic [15:0] col, inout tty_ld_pkg::out_item_t o);
    o = '0;
    o.kind = tty_ld_pkg::KindEmit;
    if (of[0] && of[1] && c == tty_ld_pkg::ChNl) begin
      o.out_first = tty_ld_pkg::ChCr; o.out_second = tty_ld_pkg::ChNl; o.out_count = 2'd2;
      col = '0;
    end else begin
      o.out_first = c; o.out_count = 2'd1;
      if (c == tty_ld_pkg::ChCr) col = '0;
      else if (c == tty_ld_pkg::ChBs) begin
        if (col != '0) col = col - 16'd1;
      end else if (c == tty_ld_pkg::ChTab) col = (col | 16'd7) + 16'd1;
      else if (c >= tty_ld_pkg::ChSpace && c < tty_ld_pkg::ChDel) col = col + 16'd1;
    end
  endfunction

  // Echo: returns 1 if an item was produced.
  function automatic logic echo(input logic [7:0] c, input logic [7:0] lf,
                                input logic [1:0] of, inout logic [15:0] col,
                                inout tty_ld_pkg::out_item_t o);
    echo = 1'b0;
    if (!lf[2]) begin
      if (c == tty_ld_pkg::ChNl && lf[5]) begin
        put_out(c, of, col, o); echo = 1'b1;
      end
    end else if (lf[4] && c < tty_ld_pkg::ChSpace && c != tty_ld_pkg::ChNl
                 && c != tty_ld_pkg::ChTab) begin
      o = '0;
      o.kind = tty_ld_pkg::KindEmit;
      o.out_first = tty_ld_pkg::ChCaret; o.out_second = c + tty_ld_pkg::ChAt;
      o.out_count = 2'd2;
      col = col + 16'd2;
      echo = 1'b1;
    end else begin
      put_out(c, of, col, o); echo = 1'b1;
    end
  endfunction

  logic [7:0] cm;
  logic [1:0] s;
  logic [IdxW-1:0] pend;
  logic [IdxW-1:0] wprev;
  logic [15:0] colv;
  tty_ld_pkg::out_item_t ot;
  logic had;
  logic at_end;
  logic [1:0] rub_n;

  always_comb begin
    state_d = state_q;
    wr_d = wr_q; rd_d = rd_q; le_d = le_q; lit_d = lit_q; col_d = col_q;
    c_d = c_q; op_d = op_q; mode_d = mode_q; sigc_d = sigc_q; wake_d = wake_q;
    eolf_d = eolf_q; ob_d = ob_q; ov_d = ov_q; hold_d = hold_q; hcnt_d = hcnt_q;
    ram_we = 1'b0; ram_wa = tty_ld_pkg::slot(wr_q);
    wprev = tty_ld_pkg::retreat(wr_q);
    ram_ra = tty_ld_pkg::slot(wprev);
    in_ch.ready = 1'b0;
    cm = c_q; s = '0; colv = col_q; ot = '0; had = 1'b0;
    pend = IdxW'((IdxW+1)'(wr_q) + (IdxW+1)'(tty_ld_pkg::RingSpan) - (IdxW+1)'(rd_q));
    if (pend >= IdxW'(tty_ld_pkg::RingSpan)) pend = pend - IdxW'(tty_ld_pkg::RingSpan);
    at_end = (wr_q == le_q);
    rub_n = (ram_rd < tty_ld_pkg::ChSpace && echoctl) ? 2'd2 : 2'd1;

    if (ov_q && out_ch.ready) ov_d = 1'b0;

    unique case (state_q)
      tty_ld_pkg::StIdle: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          c_d = in_ch.data.byte_in; op_d = in_ch.data.operation;
          sigc_d = '0; wake_d = 1'b0;
          unique case (in_ch.data.operation)
            tty_ld_pkg::OpRecv: state_d = tty_ld_pkg::StRecv;
            tty_ld_pkg::OpRead: state_d = tty_ld_pkg::StRead;
            default: state_d = tty_ld_pkg::StEmit;
          endcase
          if (in_ch.data.operation == tty_ld_pkg::OpXmit) begin
            colv = col_q;
            if (oflag_q[0]) put_out(in_ch.data.byte_in, oflag_q, colv, ot);
            else begin
              ot = '0; ot.kind = tty_ld_pkg::KindEmit;
              ot.out_first = in_ch.data.byte_in; ot.out_count = 2'd1;
            end
            col_d = colv; ot.last = 1'b1; ob_d = ot;
          end else if (in_ch.data.operation != tty_ld_pkg::OpRecv
                       && in_ch.data.operation != tty_ld_pkg::OpRead) begin
            ot = '0; ot.last = 1'b1; ob_d = ot;
          end
        end
      end

      tty_ld_pkg::StRecv: begin
        if (lit_q) begin
          lit_d = 1'b0; state_d = tty_ld_pkg::StStore;
        end else if (iflag_q[0] && c_q == tty_ld_pkg::ChCr) begin
          ob_d = '0; ob_d.last = 1'b1; state_d = tty_ld_pkg::StEmit;
        end else begin
          if (iflag_q[1] && c_q == tty_ld_pkg::ChCr) cm = tty_ld_pkg::ChNl;
          else if (iflag_q[2] && c_q == tty_ld_pkg::ChNl) cm = tty_ld_pkg::ChCr;
          c_d = cm;
          if (lflag_q[0]) begin
            if (tty_ld_pkg::match(cm, sig_q[7:0])) s = 2'd1;
            else if (tty_ld_pkg::match(cm, sig_q[15:8])) s = 2'd2;
            else if (tty_ld_pkg::match(cm, sig_q[23:16])) s = 2'd3;
          end
          if (s != 2'd0) begin
            had = echo(cm, lflag_q, oflag_q, colv, ot);
            col_d = colv;
            if (!had) ot = '0;
            if (!lflag_q[7]) begin wr_d = '0; rd_d = '0; le_d = '0; end
            ot.signal_raised = s; ot.reader_wake = 1'b1; ot.last = 1'b1;
            ob_d = ot; state_d = tty_ld_pkg::StEmit;
          end else if (canon && (tty_ld_pkg::match(cm, edit_q[7:0])
                                 || cm == tty_ld_pkg::ChBs)) begin
            mode_d = ModeErase; state_d = tty_ld_pkg::StRubRd;
          end else if (canon && tty_ld_pkg::match(cm, edit_q[15:8])) begin
            mode_d = ModeKill; state_d = tty_ld_pkg::StRubRd;
          end else if (canon && ext && tty_ld_pkg::match(cm, edit_q[23:16])) begin
            mode_d = ModeWordSp; state_d = tty_ld_pkg::StRubRd;
          end else if (canon && ext && tty_ld_pkg::match(cm, edit_q[31:24])) begin
            lit_d = 1'b1; ob_d = '0; ob_d.last = 1'b1; state_d = tty_ld_pkg::StEmit;
          end else begin
            state_d = tty_ld_pkg::StStore;
          end
        end
      end

      tty_ld_pkg::StStore: begin
        if (pend >= IdxW'(tty_ld_pkg::BufDepth - 1)) begin
          ob_d = '0; ob_d.last = 1'b1;
        end else begin
          ram_we = 1'b1;
          wr_d = tty_ld_pkg::advance(wr_q);
          if (canon && !(c_q == tty_ld_pkg::ChNl || tty_ld_pkg::match(c_q, lend_q[7:0])
                         || tty_ld_pkg::match(c_q, lend_q[15:8]))) begin
            had = echo(c_q, lflag_q, oflag_q, colv, ot);
          end else begin
            if (!(canon && tty_ld_pkg::match(c_q, lend_q[7:0])))
              had = echo(c_q, lflag_q, oflag_q, colv, ot);
            le_d = tty_ld_pkg::advance(wr_q);
            ot.reader_wake = 1'b1;
          end
          if (!had) begin
            ot.kind = tty_ld_pkg::KindNone; ot.out_first = '0;
            ot.out_second = '0; ot.out_count = '0;
          end
          col_d = colv; ot.last = 1'b1; ob_d = ot;
        end
        state_d = tty_ld_pkg::StEmit;
      end

      // Rub-out walk: read the top byte, then decide and emit.
      tty_ld_pkg::StRubRd: begin
        if (at_end) begin
          if (!ov_q || out_ch.ready) begin
            ob_d = '0; ob_d.last = 1'b1;
            if (hold_q) begin
              ob_d.kind = tty_ld_pkg::KindRub; ob_d.out_count = hcnt_q;
            end
            hold_d = 1'b0; ov_d = 1'b1; state_d = tty_ld_pkg::StIdle;
          end
        end else begin
          state_d = tty_ld_pkg::StRubWait;
        end
      end
      tty_ld_pkg::StRubWait: state_d = tty_ld_pkg::StRubChk;
      tty_ld_pkg::StRubChk: begin
        if (mode_q == ModeWordSp && ram_rd != tty_ld_pkg::ChSpace) begin
          mode_d = ModeWordCh; state_d = tty_ld_pkg::StRubRd;
        end else if (mode_q == ModeWordCh && ram_rd == tty_ld_pkg::ChSpace) begin
          if (!ov_q || out_ch.ready) begin
            ob_d = '0; ob_d.last = 1'b1;
            if (hold_q) begin
              ob_d.kind = tty_ld_pkg::KindRub; ob_d.out_count = hcnt_q;
            end
            hold_d = 1'b0; ov_d = 1'b1; state_d = tty_ld_pkg::StIdle;
          end
        end else if (!(echo_on && echoe)) begin
          wr_d = wprev;
          state_d = tty_ld_pkg::StRubRd;
          if (mode_q == ModeErase) begin
            if (!ov_q || out_ch.ready) begin
              ob_d = '0; ob_d.last = 1'b1; ov_d = 1'b1; state_d = tty_ld_pkg::StIdle;
            end else begin
              wr_d = wr_q; state_d = tty_ld_pkg::StRubChk;
            end
          end
        end else if (mode_q == ModeErase) begin
          if (!ov_q || out_ch.ready) begin
            wr_d = wprev;
            ot = '0; ot.kind = tty_ld_pkg::KindRub; ot.out_count = rub_n; ot.last = 1'b1;
            ob_d = ot; ov_d = 1'b1; state_d = tty_ld_pkg::StIdle;
          end
        end else if (!hold_q) begin
          wr_d = wprev; hold_d = 1'b1; hcnt_d = rub_n; state_d = tty_ld_pkg::StRubRd;
        end else if (!ov_q || out_ch.ready) begin
          // the held rub out is not the last: send it, hold this one
          wr_d = wprev;
          ot = '0; ot.kind = tty_ld_pkg::KindRub; ot.out_count = hcnt_q;
          ob_d = ot; ov_d = 1'b1; hcnt_d = rub_n; state_d = tty_ld_pkg::StRubRd;
        end
      end

      tty_ld_pkg::StRead: begin
        ram_ra = tty_ld_pkg::slot(rd_q);
        state_d = tty_ld_pkg::StReadWait;
      end
      tty_ld_pkg::StReadWait: begin
        ot = '0; ot.kind = tty_ld_pkg::KindRead; ot.last = 1'b1;
        if (rd_q != (canon ? le_q : wr_q)) begin
          rd_d = tty_ld_pkg::advance(rd_q);
          if (canon && tty_ld_pkg::match(ram_rd, lend_q[7:0])) ot.read_eol = 1'b1;
          else begin
            ot.read_byte = ram_rd; ot.read_valid = 1'b1;
            ot.read_eol = canon && ram_rd == tty_ld_pkg::ChNl;
          end
        end
        ob_d = ot; state_d = tty_ld_pkg::StEmit;
      end

      tty_ld_pkg::StEmit: begin
        if (!ov_q || out_ch.ready) begin
          ov_d = 1'b1; state_d = tty_ld_pkg::StIdle;
        end
      end
      default: state_d = tty_ld_pkg::StIdle;
    endcase
    // the idle engine must not start while the previous result still waits
    if (state_q == tty_ld_pkg::StIdle && ov_q && !out_ch.ready) in_ch.ready = 1'b0;
    if (state_q == tty_ld_pkg::StIdle && !in_ch.ready) begin
      state_d = tty_ld_pkg::StIdle; c_d = c_q; op_d = op_q; ob_d = ob_q; col_d = col_q;
      sigc_d = sigc_q; wake_d = wake_q;
    end
  end

  assign out_ch.valid = ov_q;
  assign out_ch.data = ob_q;

  // rub_last flags an item emitted from RubChk into an empty output register;
  // the walk then either goes on in RubRd or ends in idle. The store read in RubChk is ready.
  wire rub_last = (state_q == tty_ld_pkg::StRubChk) && ov_d && !ov_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ch.ready |=> ov_q && $stable(ob_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |-> state_q == tty_ld_pkg::StIdle)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tty_ld_pkg::StRubWait |=> state_q == tty_ld_pkg::StRubChk)
    else $error("rub-out walk lost its read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rub_last |-> state_d == tty_ld_pkg::StIdle || state_d == tty_ld_pkg::StRubRd)
    else $error("rub-out walk left its loop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == tty_ld_pkg::StStore)
    else $error("line store written outside store step");
endmodule

@@ sim/tty_ld_checker.sv @@
// Checker for the tty line discipline: watches both channels and the config port,
// predicts the result items of every accepted input and compares them in order.
// Depends on tty_ld_pkg and tty_ld_if.
`timescale 1ns / 1ps
module tty_ld_checker
  import tty_ld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  tty_ld_if                  in_ch,
  tty_ld_if                  out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 awaited_o
);
  // mirrored registers
  logic [2:0]  iflag;
  logic [7:0]  lflag;
  logic [1:0]  oflag;
  logic [23:0] sig_chars;
  logic [31:0] edit_chars;
  logic [15:0] lend_chars;
  // mirrored line state
  logic [7:0]  line_mem [BufDepth];
  logic [6:0]  wr_idx, rd_idx, eol_idx;
  bit          lit_pend;
  logic [15:0] column;
  // per-input scratch
  out_item_t   batch[$];
  logic [1:0]  sig_code;
  bit          wake;

  out_item_t   result_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign awaited_o    = result_q.size();

  function automatic logic [6:0] nxt(logic [6:0] i);
    return (i == 7'(RingSpan - 1)) ? 7'd0 : i + 7'd1;
  endfunction
  function automatic logic [6:0] prv(logic [6:0] i);
    return (i == 7'd0) ? 7'(RingSpan - 1) : i - 7'd1;
  endfunction
  function automatic int slot_of(logic [6:0] i);
    return int'(i) % BufDepth;
  endfunction
  function automatic bit hit(logic [7:0] c, logic [7:0] v);
    return v != 8'd0 && c == v;
  endfunction

  function automatic void add(logic [1:0] k, logic [7:0] a, logic [7:0] b, logic [1:0] n);
    out_item_t it;
    if (batch.size() >= 63) return;
    it = '0;
    it.kind = k;
    it.out_first = a;
    it.out_second = b;
    it.out_count = n;
    batch.push_back(it);
  endfunction

  function automatic void put_out(logic [7:0] c);
    if (oflag[0] && oflag[1] && c == ChNl) begin
      add(KindEmit, ChCr, ChNl, 2'd2);
      column = '0;
      return;
    end
    if (c == ChCr) column = '0;
    else if (c == ChBs) begin
      if (column != 0) column = column - 16'd1;
    end else if (c == ChTab) column = (column | 16'd7) + 16'd1;
    else if (c >= 8'd32 && c < ChDel) column = column + 16'd1;
    add(KindEmit, c, 8'd0, 2'd1);
  endfunction

  function automatic void echo_ch(logic [7:0] c);
    if (!lflag[2]) begin
      if (c == ChNl && lflag[5]) put_out(c);
      return;
    end
    if (lflag[4] && c < 8'd32 && c != ChNl && c != ChTab) begin
      add(KindEmit, ChCaret, c + ChAt, 2'd2);
      column = column + 16'd2;
      return;
    end
    put_out(c);
  endfunction

  function automatic void rub_one();
    logic [7:0] c;
    if (wr_idx == eol_idx) return;
    wr_idx = prv(wr_idx);
    c = line_mem[slot_of(wr_idx)];
    if (lflag[2] && lflag[3]) add(KindRub, 8'd0, 8'd0, (c < 8'd32 && lflag[4]) ? 2'd2 : 2'd1);
  endfunction

  function automatic logic [7:0] top_char();
    return line_mem[slot_of(prv(wr_idx))];
  endfunction

  function automatic void store_ch(logic [7:0] c);
    if ((int'(wr_idx) + RingSpan - int'(rd_idx)) % RingSpan >= BufDepth - 1) return;
    line_mem[slot_of(wr_idx)] = c;
    wr_idx = nxt(wr_idx);
    if (lflag[1]) begin
      if (c == ChNl || hit(c, lend_chars[7:0]) || hit(c, lend_chars[15:8])) begin
        if (!hit(c, lend_chars[7:0])) echo_ch(c);
        eol_idx = wr_idx;
        wake = 1'b1;
        return;
      end
      echo_ch(c);
    end else begin
      echo_ch(c);
      eol_idx = wr_idx;
      wake = 1'b1;
    end
  endfunction

  function automatic void take_rx(logic [7:0] c);
    logic [1:0] s;
    if (lit_pend) begin
      lit_pend = 1'b0;
      store_ch(c);
      return;
    end
    if (iflag[0] && c == ChCr) return;
    if (iflag[1] && c == ChCr) c = ChNl;
    else if (iflag[2] && c == ChNl) c = ChCr;
    if (lflag[0]) begin
      s = hit(c, sig_chars[7:0]) ? 2'd1 : hit(c, sig_chars[15:8]) ? 2'd2 :
          hit(c, sig_chars[23:16]) ? 2'd3 : 2'd0;
      if (s != 0) begin
        echo_ch(c);
        if (!lflag[7]) begin
          wr_idx = '0;
          rd_idx = '0;
          eol_idx = '0;
        end
        wake = 1'b1;
        sig_code = s;
        return;
      end
    end
    if (lflag[1]) begin
      if (hit(c, edit_chars[7:0]) || c == ChBs) begin
        rub_one();
        return;
      end
      if (hit(c, edit_chars[15:8])) begin
        while (wr_idx != eol_idx) rub_one();
        return;
      end
      if (lflag[6] && hit(c, edit_chars[23:16])) begin
        while (wr_idx != eol_idx && top_char() == ChSpace) rub_one();
        while (wr_idx != eol_idx && top_char() != ChSpace) rub_one();
        return;
      end
      if (lflag[6] && hit(c, edit_chars[31:24])) begin
        lit_pend = 1'b1;
        return;
      end
    end
    store_ch(c);
  endfunction

  function automatic void pop_one();
    logic [6:0] lim;
    logic [7:0] c;
    out_item_t  it;
    lim = lflag[1] ? eol_idx : wr_idx;
    it = '0;
    it.kind = KindRead;
    if (rd_idx != lim) begin
      c = line_mem[slot_of(rd_idx)];
      rd_idx = nxt(rd_idx);
      if (lflag[1] && hit(c, lend_chars[7:0])) it.read_eol = 1'b1;
      else begin
        it.read_byte = c;
        it.read_valid = 1'b1;
        it.read_eol = lflag[1] && c == ChNl;
      end
    end
    batch.push_back(it);
  endfunction

  function automatic void predict(in_item_t x);
    out_item_t it;
    batch.delete();
    sig_code = '0;
    wake = 1'b0;
    case (x.operation)
      OpRecv: take_rx(x.byte_in);
      OpRead: pop_one();
      OpXmit: begin
        if (oflag[0]) put_out(x.byte_in);
        else add(KindEmit, x.byte_in, 8'd0, 2'd1);
      end
      default: ;
    endcase
    if (batch.size() == 0) add(KindNone, 8'd0, 8'd0, 2'd0);
    it = batch.pop_back();
    it.signal_raised = sig_code;
    it.reader_wake = wake;
    it.last = 1'b1;
    batch.push_back(it);
    foreach (batch[i]) result_q.push_back(batch[i]);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  function automatic void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] d);
    case (idx)
      RegIflag: iflag = d[2:0];
      RegLflag: begin
        if (lflag[1] && !d[1]) eol_idx = wr_idx;
        lflag = d[7:0];
      end
      RegOflag: oflag = d[1:0];
      RegSig:   sig_chars = d[23:0];
      RegEdit:  edit_chars = d;
      RegLend:  lend_chars = d[15:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got, want;
    if (!rst_ni) begin
      iflag = 3'd2;
      lflag = 8'd95;
      oflag = 2'd3;
      sig_chars = 24'h1A1C03;
      edit_chars = 32'h1617157F;
      lend_chars = 16'h0004;
      wr_idx = '0;
      rd_idx = '0;
      eol_idx = '0;
      lit_pend = 1'b0;
      column = '0;
      result_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      if (in_ch.valid && in_ch.ready) predict(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (result_q.size() == 0) report("unexpected transfer", 32'(got), 0);
        else begin
          want = result_q.pop_front();
          if (got.kind != want.kind) report("kind", got.kind, want.kind);
          if (got.out_first != want.out_first) report("out_first", got.out_first, want.out_first);
          if (got.out_second != want.out_second)
            report("out_second", got.out_second, want.out_second);
          if (got.out_count != want.out_count) report("out_count", got.out_count, want.out_count);
          if (got.signal_raised != want.signal_raised)
            report("signal_raised", got.signal_raised, want.signal_raised);
          if (got.reader_wake != want.reader_wake)
            report("reader_wake", got.reader_wake, want.reader_wake);
          if (got.read_byte != want.read_byte) report("read_byte", got.read_byte, want.read_byte);
          if (got.read_valid != want.read_valid)
            report("read_valid", got.read_valid, want.read_valid);
          if (got.read_eol != want.read_eol) report("read_eol", got.read_eol, want.read_eol);
          if (got.last != want.last) report("last", got.last, want.last);
        end
      end
    end
  end
endmodule

@@ sim/tty_canonical_line_discipline_tb.sv @@
// Top of the tty line discipline testbench: clock, reset, stimulus and verdict.
// Depends on tty_ld_pkg, tty_ld_if, the block and tty_ld_checker.
`timescale 1ns / 1ps
module tty_canonical_line_discipline_tb;
  import tty_ld_pkg::*;

  localparam int StallLimit = 3000;
  localparam int Drain = 250;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  int                 fail_count;
  int                 awaited;
  int                 tx_idle_pct, rx_idle_pct;
  bit                 in_taken;
  int                 quiet_cycles;

  tty_ld_if #(.payload_t(in_item_t))  in_ch ();
  tty_ld_if #(.payload_t(out_item_t)) out_ch ();

  tty_canonical_line_discipline i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  tty_ld_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .awaited_o   (awaited)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    tx_idle_pct = 29;
    rx_idle_pct = 86;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) in_taken <= in_ch.valid && in_ch.ready;

  always @(negedge clk_i) out_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data = {op, b};
    do @(negedge clk_i); while (!in_taken);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] d);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = d;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    while (awaited != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'($urandom_range(8'h21, 8'h7e));
    if (r < 45) return ChSpace;
    if (r < 53) return ChNl;
    if (r < 57) return ChCr;
    if (r < 62) return ($urandom_range(0, 1) != 0) ? ChDel : ChBs;
    if (r < 65) return 8'h15;
    if (r < 69) return 8'h17;
    if (r < 71) return 8'h16;
    if (r < 74) return 8'($urandom_range(0, 2) == 0 ? 8'h03 : ($urandom_range(0, 1) ? 8'h1c : 8'h1a));
    if (r < 77) return 8'h04;
    if (r < 79) return 8'h3b;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly typed lines with edits, mixed with reads, transmits and spare operations
  task automatic random_traffic(int n_items);
    int sent, r, k;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        for (k = 0; k < 70; k++) send(OpRecv, 8'($urandom_range(8'h20, 8'h7e)));
        sent += 70;
      end else if (r < 60) begin
        send(OpRecv, pick_char());
        sent++;
      end else if (r < 85) begin
        k = $urandom_range(1, 8);
        repeat (k) send(OpRead, 8'($urandom_range(0, 255)));
        sent += k;
      end else if (r < 98) begin
        send(OpXmit, ($urandom_range(0, 3) == 0) ? ChNl : pick_char());
        sent++;
      end else begin
        send(OpSpare, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] dir_rx[] = '{8'h61, 8'h00, 8'hff, ChDel, 8'h62, ChSpace, 8'h63, 8'h17,
                             8'h16, 8'h03, ChCr, 8'h04, 8'h1c, 8'h1a};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: edits, literal next, line ends, reads, transmit, signals
    foreach (dir_rx[i]) send(OpRecv, dir_rx[i]);
    repeat (4) send(OpRead, 8'h00);
    send(OpRecv, 8'h04);
    send(OpRead, 8'hff);
    send(OpRead, 8'h00);
    send(OpXmit, ChNl);
    send(OpXmit, ChTab);
    send(OpXmit, 8'hff);
    send(OpSpare, 8'h55);
    send(OpRecv, 8'h61);
    send(OpRecv, 8'h15);
    random_traffic(80);
    settle();

    write_reg(RegIflag, 32'd4);
    write_reg(RegLflag, 32'hff);
    write_reg(RegOflag, 32'd1);
    write_reg(RegSig, 32'h1A1C03);
    write_reg(RegEdit, 32'h1617157F);
    write_reg(RegLend, 32'h3B04);
    random_traffic(100);
    settle();

    tx_idle_pct = 86;
    rx_idle_pct = 29;
    write_reg(RegIflag, 32'd0);
    write_reg(RegLflag, 32'h00);
    write_reg(RegOflag, 32'd0);
    write_reg(RegSig, 32'h0);
    write_reg(RegEdit, 32'h0);
    write_reg(RegLend, 32'h0);
    random_traffic(100);
    settle();

    write_reg(RegIflag, 32'd7);
    write_reg(RegLflag, 32'h7e);
    write_reg(RegOflag, 32'd2);
    write_reg(RegSig, 32'hffffff);
    write_reg(RegEdit, 32'hffffffff);
    write_reg(RegLend, 32'hffff);
    random_traffic(100);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(RegIflag, 32'd2);
    write_reg(RegLflag, 32'h5f);
    write_reg(RegOflag, 32'd3);
    write_reg(RegSig, 32'h1A1C03);
    write_reg(RegEdit, 32'h1617157F);
    write_reg(RegLend, 32'h0004);
    random_traffic(100);
    settle();

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

@@ files.f @@
hdl/tty_ld_pkg.sv
hdl/tty_ld_if.sv
hdl/tty_ld_ram.sv
hdl/tty_canonical_line_discipline.sv
sim/tty_ld_checker.sv
sim/tty_canonical_line_discipline_tb.sv
